/* design/clsr_pkg.sv */
// Shared constants and types of the combined multiplicative generator.
package clsr_pkg;

    localparam int VAL_W  = 31;
    localparam int MUL_W  = 16;
    localparam int FOLD_W = 8;

    localparam logic [VAL_W-1:0] MOD_ONE       = 31'd2147483563;
    localparam logic [VAL_W-1:0] MOD_TWO       = 31'd2147483399;
    localparam logic [VAL_W-1:0] WRAP_TOP      = 31'd2147483562;
    localparam logic [VAL_W-1:0] GEN_ONE_RESET = 31'd1;
    localparam logic [VAL_W-1:0] GEN_TWO_RESET = 31'd123456789;

    localparam logic [MUL_W-1:0] MUL_ONE = 16'd40014;
    localparam logic [MUL_W-1:0] MUL_TWO = 16'd40692;

    // 2^31 minus each modulus: the weight of the product's upper half.
    localparam logic [FOLD_W-1:0] FOLD_ONE = 8'd85;
    localparam logic [FOLD_W-1:0] FOLD_TWO = 8'd249;

    typedef enum logic {
        GEN_ONE,
        GEN_TWO
    } t_gen_sel;

    typedef struct packed {
        t_gen_sel         sel;
        logic [VAL_W-1:0] x;
    } t_lmr_req;

endpackage

/* design/clsr_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module clsr_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/clsr_lehmer.sv */
// Shared Lehmer step unit: registered 31x16 product, then fold and one correction.
module clsr_lehmer
    import clsr_pkg::*;
(
    input  logic             i_clk,
    input  t_lmr_req         i_req,
    output logic [VAL_W-1:0] o_res
);

    localparam int PROD_W = VAL_W + MUL_W;
    localparam int HIFW   = MUL_W + FOLD_W;

    logic [PROD_W-1:0] r_prod;
    t_gen_sel          r_sel;
    logic [MUL_W-1:0]  mul;
    logic [FOLD_W-1:0] fold_c;
    logic [VAL_W-1:0]  modulus;
    logic [HIFW-1:0]   fold;
    logic [VAL_W:0]    sum;
    logic [VAL_W:0]    red;

    assign mul = (i_req.sel == GEN_TWO) ? MUL_TWO : MUL_ONE;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_req.x) * PROD_W'(mul);
        r_sel  <= i_req.sel;
    end

    assign fold_c  = (r_sel == GEN_TWO) ? FOLD_TWO : FOLD_ONE;
    assign modulus = (r_sel == GEN_TWO) ? MOD_TWO : MOD_ONE;

    // Since 2^31 is congruent to the fold constant, the sum stays below twice
    // the modulus, so a single conditional subtraction completes the reduction.
    assign fold = HIFW'(r_prod[PROD_W-1:VAL_W]) * HIFW'(fold_c);
    assign sum  = {1'b0, r_prod[VAL_W-1:0]} + (VAL_W+1)'(fold);
    assign red  = (sum >= {1'b0, modulus}) ? (sum - {1'b0, modulus}) : sum;

    assign o_res = red[VAL_W-1:0];

endmodule

/* design/combined_lcg_shuffle_rng.sv */
// Combined two-generator random number source with a shuffle table.
// A draw runs two passes of the shared Lehmer unit, a slot calculation by reciprocal estimate,
// remainder step and correction, and the registered table read; no new transaction is taken
// until the draw finishes, and the finish waits while the previous output is still held.
// A reseed steps generator one TABLE_DEPTH+8 times, the last TABLE_DEPTH filling the table.
// Synchronous reset restores the generators, clears o_valid and marks the table as zero.
module combined_lcg_shuffle_rng
    import clsr_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_op,
    input  logic [VAL_W-1:0] i_seed,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [VAL_W-1:0] o_value
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 8);
    localparam int RW = AW + 2;
    localparam int DW = VAL_W + AW;
    localparam logic [31:0] SLOT_DIV = 32'(WRAP_TOP) / 32'(TABLE_DEPTH) + 32'd1;
    localparam logic [DW-1:0] SLOT_DIV_W = DW'(SLOT_DIV);
    localparam logic [VAL_W-1:0] SLOT_DIV_V = VAL_W'(SLOT_DIV);
    localparam logic [RW-1:0] SLOT_RECIP = RW'(32'h8000_0000 / SLOT_DIV);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEED_MUL,
        S_SEED_RED,
        S_DRAW_ONE,
        S_DRAW_TWO,
        S_DRAW_RED,
        S_READ,
        S_FINISH
    } t_state;

    t_state                 r_state;
    logic [VAL_W-1:0]       r_gen_one;
    logic [VAL_W-1:0]       r_gen_two;
    logic [VAL_W-1:0]       r_last;
    logic [TABLE_DEPTH-1:0] r_vld;
    logic [CW-1:0]          r_cnt;
    logic [VAL_W-1:0]       r_rem;
    logic [AW-1:0]          r_quo;
    logic                   r_out_valid;
    logic [VAL_W-1:0]       r_out_value;

    t_lmr_req            lmr_req;
    logic [VAL_W-1:0]    lmr_res;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [VAL_W-1:0]    ram_wdata;
    logic                ram_re;
    logic [VAL_W-1:0]    ram_rdata;
    logic                seed_fill;
    logic                out_free;
    logic                finish_fire;
    logic [VAL_W+RW-1:0] recip_prod;
    logic [AW-1:0]       quo_est;
    logic [DW-1:0]       base_prod;
    logic [VAL_W-1:0]    tab_val;
    logic [VAL_W:0]      diff;
    logic [VAL_W:0]      wrapped;
    logic [VAL_W-1:0]    draw_value;

    assign lmr_req.sel = (r_state == S_DRAW_TWO) ? GEN_TWO : GEN_ONE;
    assign lmr_req.x   = (r_state == S_DRAW_TWO) ? r_gen_two : r_gen_one;

    clsr_lehmer u_lehmer (
        .i_clk (i_clk),
        .i_req (lmr_req),
        .o_res (lmr_res)
    );

    // The slot is first estimated by a reciprocal multiplication, which can fall one short;
    // the remainder left over then decides whether it is raised by one.
    assign recip_prod = (VAL_W+RW)'(r_last) * (VAL_W+RW)'(SLOT_RECIP);
    assign quo_est    = recip_prod[VAL_W +: AW];
    assign base_prod  = DW'(r_quo) * SLOT_DIV_W;

    assign out_free    = !r_out_valid || i_ready;
    assign seed_fill   = (r_state == S_SEED_RED) && (r_cnt < CW'(TABLE_DEPTH));
    assign finish_fire = (r_state == S_FINISH) && out_free;

    assign ram_we    = seed_fill || finish_fire;
    assign ram_waddr = (r_state == S_SEED_RED) ? r_cnt[AW-1:0] : r_quo;
    assign ram_wdata = (r_state == S_SEED_RED) ? lmr_res : r_gen_one;
    assign ram_re    = (r_state == S_READ);

    clsr_ram #(
        .WIDTH (VAL_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_quo),
        .o_rdata (ram_rdata)
    );

    // An entry never written since reset reads as zero.
    assign tab_val    = r_vld[r_quo] ? ram_rdata : '0;
    assign diff       = {1'b0, tab_val} - {1'b0, r_gen_two};
    assign wrapped    = diff + {1'b0, WRAP_TOP};
    assign draw_value = (tab_val > r_gen_two) ? diff[VAL_W-1:0] : wrapped[VAL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_gen_one   <= GEN_ONE_RESET;
            r_gen_two   <= GEN_TWO_RESET;
            r_last      <= '0;
            r_vld       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready && !finish_fire) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        if (i_op) begin
                            r_gen_one <= (i_seed == '0) ? VAL_W'(1) : i_seed;
                            r_gen_two <= (i_seed == '0) ? VAL_W'(1) : i_seed;
                            r_cnt     <= CW'(TABLE_DEPTH + 7);
                            r_state   <= S_SEED_MUL;
                        end else begin
                            r_state <= S_DRAW_ONE;
                        end
                    end
                end
                S_SEED_MUL: begin
                    r_state <= S_SEED_RED;
                end
                S_SEED_RED: begin
                    r_gen_one <= lmr_res;
                    if (seed_fill) begin
                        r_vld[r_cnt[AW-1:0]] <= 1'b1;
                    end
                    if (r_cnt == '0) begin
                        r_last  <= lmr_res;
                        r_state <= S_DRAW_ONE;
                    end else begin
                        r_cnt   <= r_cnt - CW'(1);
                        r_state <= S_SEED_MUL;
                    end
                end
                S_DRAW_ONE: begin
                    r_rem   <= r_last;
                    r_quo   <= quo_est;
                    r_state <= S_DRAW_TWO;
                end
                S_DRAW_TWO: begin
                    r_gen_one <= lmr_res;
                    r_rem     <= r_rem - base_prod[VAL_W-1:0];
                    r_state   <= S_DRAW_RED;
                end
                S_DRAW_RED: begin
                    r_gen_two <= lmr_res;
                    if (r_rem >= SLOT_DIV_V) begin
                        r_quo <= r_quo + AW'(1);
                    end
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_vld[r_quo] <= 1'b1;
                        r_last       <= draw_value;
                        r_out_value  <= draw_value;
                        r_out_valid  <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_value = r_out_value;

    // A delivered value always lies in the wrapped output range.
    a_value_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_value != '0) && (o_value <= WRAP_TOP))
        else $error("output value outside 1..WRAP_TOP");

    // The table is only ever read at a slot that exists.
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_re |-> (r_quo <= AW'(TABLE_DEPTH - 1)))
        else $error("slot index beyond the table");

    // Taking a transaction always starts work that blocks the input side.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input accepted twice in a row");

    // A table write only happens while filling on reseed or finishing a draw.
    a_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_SEED_RED) || (r_state == S_FINISH))
        else $error("table written outside reseed fill or draw completion");

endmodule
